FILE: sv/spimfc_pkg.sv
// shared types and constants for the spi frame fetch block
`default_nettype none

package spimfc_pkg;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_GAP  = 3'd1,
      PH_LOW  = 3'd2,
      PH_HIGH = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_HALF_PERIOD = 3'd0,
      CSR_BYTE_GAP    = 3'd1,
      CSR_COMMAND     = 3'd2,
      CSR_DUMMY       = 3'd3,
      CSR_FILL        = 3'd4,
      CSR_DATA_COUNT  = 3'd5
   } csr_index_type;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 24;
   // bits of rsp_tdata that carry fields, the rest is padding
   localparam int unsigned RspFieldBits = 20;

   // reset values of the registers
   localparam logic [15:0] HalfPeriodReset = 16'd1000;
   localparam logic [15:0] ByteGapReset    = 16'd225;
   localparam logic [7:0]  CommandReset    = 8'd97;
   localparam logic [7:0]  DummyReset      = 8'd0;
   localparam logic [7:0]  FillReset       = 8'd10;
   localparam logic [6:0]  DataCountReset  = 7'd30;

   localparam logic [6:0]  DataCountMax    = 7'd64;
   localparam logic [6:0]  HeaderBytes     = 7'd2;

endpackage

`default_nettype wire

FILE: sv/spi_master_frame_fetch_checksum.sv
// spi mode-0 master that fetches a sensor frame and checks its additive checksum
//
// Each item on the req channel is one tick of the bit sequencer and carries
// start_req and the sampled miso level. For every accepted item exactly one
// item leaves on the rsp channel with the line levels (cs_n, sck, mosi) for
// that tick, a received data byte with its index when byte_valid is set, and
// frame_done (on rsp_tlast) with checksum_ok on the final tick of a frame.
// The sequencer state and the result register are both written at the edge
// that accepts the item, so a result is shown in the cycle after its item is
// taken; one item per cycle is sustained as long as the receiver takes them.
// When rsp_tready is low the result register holds its item and req_tready
// drops until it is taken, so the sequencer simply stops advancing.
// Registers are written on the csr port and act on the next tick. Reset puts
// the sequencer in idle with counters and sums cleared, loads the register
// defaults and empties the result register.
`default_nettype none

module spi_master_frame_fetch_checksum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req_tdata: start_req, miso, zero padding
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [spimfc_pkg::ReqDataWidth-1:0]   req_tdata,
   // rsp_tdata: cs_n, sck, mosi, byte_valid, byte_value[7:0], byte_index[5:0],
   // checksum_ok, busy_res, zero padding; rsp_tlast: frame_done
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [spimfc_pkg::RspDataWidth-1:0]        rsp_tdata,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_we,
   input  wire logic [spimfc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire logic [spimfc_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // configuration registers
   logic [15:0] half_ff, gap_ff;
   logic [7:0]  command_ff, dummy_ff, fill_ff;
   logic [6:0]  count_ff;

   // sequencer state
   spimfc_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [6:0]  byte_ff, byte_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [7:0]  sum_ff, sum_in;

   // result register
   logic        rsp_valid_ff;
   logic [spimfc_pkg::RspFieldBits-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_fire;
   logic        start_req, miso;

   logic        cs_n, sck, mosi, byte_valid, frame_done, checksum_ok, busy_res;
   logic [7:0]  byte_value;
   logic [5:0]  byte_index;

   logic [16:0] tick_inc;
   logic [15:0] half_eff;
   logic [6:0]  count_eff, last_pos, byte_inc, data_pos;
   logic [2:0]  bit_inc;
   logic        gap_done, half_done;
   logic [7:0]  rx_cur;
   spimfc_pkg::phase_type start_phase;

   assign start_req = req_tdata[0];
   assign miso      = req_tdata[1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= spimfc_pkg::HalfPeriodReset;
         gap_ff     <= spimfc_pkg::ByteGapReset;
         command_ff <= spimfc_pkg::CommandReset;
         dummy_ff   <= spimfc_pkg::DummyReset;
         fill_ff    <= spimfc_pkg::FillReset;
         count_ff   <= spimfc_pkg::DataCountReset;
      end else if (csr_we) begin
         unique case (spimfc_pkg::csr_index_type'(csr_addr))
            spimfc_pkg::CSR_HALF_PERIOD: half_ff    <= csr_wdata;
            spimfc_pkg::CSR_BYTE_GAP:    gap_ff     <= csr_wdata;
            spimfc_pkg::CSR_COMMAND:     command_ff <= csr_wdata[7:0];
            spimfc_pkg::CSR_DUMMY:       dummy_ff   <= csr_wdata[7:0];
            spimfc_pkg::CSR_FILL:        fill_ff    <= csr_wdata[7:0];
            spimfc_pkg::CSR_DATA_COUNT:  count_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // shared arithmetic for the step
   assign tick_inc  = {1'b0, tick_ff} + 17'd1;
   assign half_eff  = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign gap_done  = tick_inc >= {1'b0, gap_ff};
   assign half_done = tick_inc >= {1'b0, half_eff};
   assign count_eff = (count_ff == 7'd0) ? 7'd1 :
                      (count_ff > spimfc_pkg::DataCountMax) ? spimfc_pkg::DataCountMax :
                      count_ff;
   assign last_pos  = spimfc_pkg::HeaderBytes + count_eff;
   assign byte_inc  = byte_ff + 7'd1;
   assign data_pos  = byte_ff - spimfc_pkg::HeaderBytes;
   assign bit_inc   = bit_ff + 3'd1;
   // miso is taken on the first high tick of each bit
   assign rx_cur    = (tick_ff == 16'd0) ? {rx_ff[6:0], miso} : rx_ff;
   assign start_phase = (gap_ff == 16'd0) ? spimfc_pkg::PH_LOW : spimfc_pkg::PH_GAP;

   always_comb begin
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      byte_in     = byte_ff;
      tick_in     = tick_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      sum_in      = sum_ff;
      cs_n        = 1'b0;
      sck         = 1'b0;
      mosi        = 1'b0;
      byte_valid  = 1'b0;
      byte_value  = 8'd0;
      byte_index  = 6'd0;
      frame_done  = 1'b0;
      checksum_ok = 1'b0;
      busy_res    = 1'b1;
      unique case (phase_ff)
         spimfc_pkg::PH_GAP: begin
            if (gap_done) begin
               phase_in = spimfc_pkg::PH_LOW;
               tick_in  = 16'd0;
            end else begin
               tick_in = tick_inc[15:0];
            end
         end
         spimfc_pkg::PH_LOW: begin
            mosi = tx_ff[7];
            if (half_done) begin
               phase_in = spimfc_pkg::PH_HIGH;
               tick_in  = 16'd0;
            end else begin
               tick_in = tick_inc[15:0];
            end
         end
         spimfc_pkg::PH_HIGH: begin
            sck   = 1'b1;
            mosi  = tx_ff[7];
            rx_in = rx_cur;
            if (half_done) begin
               tick_in = 16'd0;
               tx_in   = {tx_ff[6:0], 1'b0};
               bit_in  = bit_inc;
               if (bit_inc != 3'd0) begin
                  phase_in = spimfc_pkg::PH_LOW;
               end else if (byte_ff >= last_pos) begin
                  // checksum byte received
                  phase_in = spimfc_pkg::PH_END;
               end else begin
                  if (byte_ff >= spimfc_pkg::HeaderBytes) begin
                     byte_valid = 1'b1;
                     byte_value = rx_cur;
                     byte_index = data_pos[5:0];
                     sum_in     = sum_ff + rx_cur;
                  end
                  byte_in  = byte_inc;
                  tx_in    = (byte_inc == 7'd1) ? dummy_ff : fill_ff;
                  phase_in = start_phase;
               end
            end else begin
               tick_in = tick_inc[15:0];
            end
         end
         spimfc_pkg::PH_END: begin
            frame_done  = 1'b1;
            checksum_ok = (rx_ff == sum_ff);
            phase_in    = spimfc_pkg::PH_IDLE;
         end
         default: begin
            cs_n     = 1'b1;
            busy_res = 1'b0;
            phase_in = spimfc_pkg::PH_IDLE;
            if (start_req) begin
               byte_in  = 7'd0;
               sum_in   = 8'd0;
               rx_in    = 8'd0;
               tx_in    = command_ff;
               bit_in   = 3'd0;
               tick_in  = 16'd0;
               phase_in = start_phase;
            end
         end
      endcase
   end

   assign rsp_data_in = {busy_res, checksum_ok, byte_index, byte_value,
                         byte_valid, mosi, sck, cs_n};
   assign rsp_last_in = frame_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spimfc_pkg::PH_IDLE;
         bit_ff   <= 3'd0;
         byte_ff  <= 7'd0;
         tick_ff  <= 16'd0;
         tx_ff    <= 8'd0;
         rx_ff    <= 8'd0;
         sum_ff   <= 8'd0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         tick_ff  <= tick_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(spimfc_pkg::RspDataWidth - spimfc_pkg::RspFieldBits){1'b0}},
                        rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a data byte and the frame end never share a tick
   a_byte_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[3] && rsp_last_ff))
      else $error("data byte reported on the frame end tick");

   // deselected slave sees an idle clock and the block is not busy
   a_cs_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> (!rsp_data_ff[1] && !rsp_data_ff[19]))
      else $error("clock or busy while chip select is high");

   // the frame end lasts one tick
   a_end_one_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == spimfc_pkg::PH_END) |=> (phase_ff == spimfc_pkg::PH_IDLE))
      else $error("frame end phase did not return to idle");

   // bit position only moves inside a byte transfer
   a_bit_in_transfer: assert property (@(posedge clock) disable iff (reset)
      (bit_ff != 3'd0) |->
         (phase_ff == spimfc_pkg::PH_LOW || phase_ff == spimfc_pkg::PH_HIGH))
      else $error("bit counter nonzero outside a transfer");

   // tick counter is cleared whenever the sequencer is idle or ending
   a_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == spimfc_pkg::PH_IDLE || phase_ff == spimfc_pkg::PH_END) |->
         (tick_ff == 16'd0))
      else $error("tick counter not cleared");

endmodule

`default_nettype wire
